// ----- src/ppa_pkg.sv -----
// Shared types and constants for the polygon perimeter/area block.
package ppa_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int MAX_VERTICES = 1024;
  localparam int LEN_BITS     = 36;
  localparam int AREA_BITS    = 41;
  localparam int CROSS_BITS   = 42;
  localparam int COUNT_BITS   = 11;
  localparam int COUNT_CAP    = (MAX_VERTICES < 2047) ? MAX_VERTICES : 2047;
  // squared edge length: two (COORD_BITS+1)^2 terms, scaled by 2^(2*FRAC_BITS)
  localparam int SQ_BITS      = 2 * (COORD_BITS + 1) + 1 + 2 * FRAC_BITS;
  localparam int ROOT_BITS    = (SQ_BITS + 1) / 2;
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int DIFF_BITS    = PROD_BITS + 1;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);

  localparam logic [LEN_BITS-1:0]   LEN_MAX  = '1;
  localparam logic [AREA_BITS-1:0]  AREA_MAX = '1;
  localparam logic signed [CROSS_BITS-1:0] CROSS_HI = {1'b0, {(CROSS_BITS-1){1'b1}}};
  localparam logic signed [CROSS_BITS-1:0] CROSS_LO = {1'b1, {(CROSS_BITS-1){1'b0}}};

  localparam logic ADDR_CLOSED_PATH = 1'b0;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic                         last_vertex;
  } vertex_t;

  typedef struct packed {
    logic [LEN_BITS-1:0]   perimeter_q8;
    logic [AREA_BITS-1:0]  area_halves;
    logic [COUNT_BITS-1:0] vertex_count;
    logic                  saturated;
  } result_t;

  // edge as queued between front and back
  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic                         is_first;  // opens a path, no edge
    logic                         is_close;  // closing edge, ends path
    logic                         is_final;  // emit result after this
    logic                         count_it;  // counts as a vertex
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_ACC,
    BK_OUT
  } back_state_t;

endpackage

// ----- src/ppa_front.sv -----
// Front end: holds first/previous vertex and turns each vertex into edge operations.
module ppa_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            closed_path,
  input  logic            in_valid,
  output logic            in_stall,
  input  ppa_pkg::vertex_t in_word,
  output logic            op_valid,
  input  logic            op_stall,
  output ppa_pkg::op_t    op_word
);
  import ppa_pkg::*;

  logic signed [COORD_BITS-1:0] first_x, first_y, prev_x, prev_y;
  logic in_path;
  logic close_pending;  // closing edge still to issue
  logic signed [COORD_BITS-1:0] last_x, last_y;

  logic take;

  always_comb begin
    op_word = '0;
    if (close_pending) begin
      op_word.ax = last_x;
      op_word.ay = last_y;
      op_word.bx = first_x;
      op_word.by = first_y;
      op_word.is_close = 1'b1;
      op_word.is_final = 1'b1;
    end else begin
      op_word.ax = prev_x;
      op_word.ay = prev_y;
      op_word.bx = in_word.x_coord;
      op_word.by = in_word.y_coord;
      op_word.is_first = !in_path;
      op_word.count_it = 1'b1;
      op_word.is_final = in_word.last_vertex && !closed_path;
    end
  end

  assign op_valid = close_pending || in_valid;
  assign in_stall = close_pending || op_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_path <= 1'b0;
      close_pending <= 1'b0;
      first_x <= '0;
      first_y <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      if (close_pending && !op_stall) begin
        close_pending <= 1'b0;
      end
      if (take) begin
        prev_x <= in_word.x_coord;
        prev_y <= in_word.y_coord;
        last_x <= in_word.x_coord;
        last_y <= in_word.y_coord;
        if (!in_path) begin
          first_x <= in_word.x_coord;
          first_y <= in_word.y_coord;
        end
        in_path <= !in_word.last_vertex;
        close_pending <= in_word.last_vertex && closed_path;
      end
    end
  end

endmodule

// ----- src/ppa_queue.sv -----
// Short FIFO of edge operations between front and back.
module ppa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_stall,
  input  ppa_pkg::op_t  wr_word,
  output logic          rd_valid,
  input  logic          rd_stall,
  output ppa_pkg::op_t  rd_word
);
  import ppa_pkg::*;

  op_t entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   fill;
  logic push, pop;

  assign wr_stall = (fill == (QPTR_BITS+1)'(QDEPTH));
  assign rd_valid = (fill != '0);
  assign rd_word  = entries[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end
  end

endmodule

// ----- src/ppa_back.sv -----
// Back end: edge length by bit-serial square root, cross terms, saturating sums.
module ppa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_valid,
  output logic             op_stall,
  input  ppa_pkg::op_t     op_word,
  output logic             out_valid,
  input  logic             out_stall,
  output ppa_pkg::result_t out_word
);
  import ppa_pkg::*;

  back_state_t state, state_next;

  op_t cur;
  logic [SQ_BITS-1:0]   rem;
  logic [ROOT_BITS-1:0] root;
  logic [$clog2(ROOT_BITS+1)-1:0] step;
  logic signed [DIFF_BITS-1:0] cross_term;

  logic [LEN_BITS-1:0]   length_sum;
  logic signed [CROSS_BITS-1:0] cross_sum;
  logic [COUNT_BITS-1:0] count;
  logic                  overflow_seen;

  logic take;
  assign op_stall = (state != BK_IDLE);
  assign take = op_valid && !op_stall;
  assign out_valid = (state == BK_OUT);

  // load path
  logic [COORD_BITS:0] dx, dy;
  logic signed [COORD_BITS:0] ddx, ddy;
  logic [2*COORD_BITS+1:0] dx_sq, dy_sq;
  always_comb begin
    ddx = $signed({op_word.bx[COORD_BITS-1], op_word.bx})
          - $signed({op_word.ax[COORD_BITS-1], op_word.ax});
    ddy = $signed({op_word.by[COORD_BITS-1], op_word.by})
          - $signed({op_word.ay[COORD_BITS-1], op_word.ay});
    dx = ddx[COORD_BITS] ? (COORD_BITS+1)'(-ddx) : ddx;
    dy = ddy[COORD_BITS] ? (COORD_BITS+1)'(-ddy) : ddy;
    dx_sq = dx * dx;
    dy_sq = dy * dy;
  end

  // one root bit per cycle, restoring method
  logic [SQ_BITS-1:0] trial;
  logic [$clog2(ROOT_BITS+1)-1:0] bitpos;
  always_comb begin
    bitpos = ($clog2(ROOT_BITS+1))'(ROOT_BITS - 1) - step;
    trial  = (SQ_BITS'(root) << (bitpos + 1)) | (SQ_BITS'(1) << (2 * bitpos));
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (take) state_next = op_word.is_first ? BK_ACC : BK_ROOT;
      BK_ROOT: if (step == ($clog2(ROOT_BITS+1))'(ROOT_BITS - 1)) state_next = BK_ACC;
      BK_ACC:  state_next = cur.is_final ? BK_OUT : BK_IDLE;
      BK_OUT:  if (!out_stall) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  logic [LEN_BITS:0] len_add;
  logic signed [CROSS_BITS+1:0] cross_add;
  logic [CROSS_BITS-1:0] cross_abs;
  always_comb begin
    len_add   = {1'b0, length_sum} + (LEN_BITS+1)'(root);
    cross_add = (CROSS_BITS+2)'(cross_sum) + (CROSS_BITS+2)'(cross_term);
    cross_abs = cross_sum[CROSS_BITS-1] ? CROSS_BITS'(-cross_sum) : CROSS_BITS'(cross_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      length_sum <= '0;
      cross_sum <= '0;
      count <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        BK_IDLE: begin
          if (take) begin
            cur   <= op_word;
            root  <= '0;
            step  <= '0;
            rem   <= (SQ_BITS'(dx_sq) + SQ_BITS'(dy_sq)) << (2 * FRAC_BITS);
            cross_term <= DIFF_BITS'(op_word.ax * op_word.by)
                          - DIFF_BITS'(op_word.bx * op_word.ay);
            if (op_word.is_first) begin
              length_sum <= '0;
              cross_sum <= '0;
              count <= COUNT_BITS'(1);
              overflow_seen <= 1'b0;
            end
          end
        end
        BK_ROOT: begin
          step <= step + 1'b1;
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= root | (ROOT_BITS'(1) << bitpos);
          end
        end
        BK_ACC: begin
          if (!cur.is_first) begin
            if (len_add[LEN_BITS]) begin
              length_sum <= LEN_MAX;
              overflow_seen <= 1'b1;
            end else begin
              length_sum <= len_add[LEN_BITS-1:0];
            end
            if (cross_add > (CROSS_BITS+2)'(CROSS_HI)) begin
              cross_sum <= CROSS_HI;
              overflow_seen <= 1'b1;
            end else if (cross_add < (CROSS_BITS+2)'(CROSS_LO)) begin
              cross_sum <= CROSS_LO;
              overflow_seen <= 1'b1;
            end else begin
              cross_sum <= cross_add[CROSS_BITS-1:0];
            end
            if (cur.count_it) begin
              if (count < COUNT_BITS'(COUNT_CAP)) count <= count + 1'b1;
              else overflow_seen <= 1'b1;
            end
          end
        end
        BK_OUT: ;
        default: ;
      endcase
    end
  end

  // closing edge only appears in closed mode; the area overflow is judged here
  logic area_sat;
  always_comb begin
    area_sat = cur.is_close && cross_abs[CROSS_BITS-1];
    out_word.perimeter_q8 = length_sum;
    out_word.area_halves  = !cur.is_close ? '0 :
                            area_sat ? AREA_MAX : cross_abs[AREA_BITS-1:0];
    out_word.vertex_count = count;
    out_word.saturated    = overflow_seen || area_sat;
  end

endmodule

// ----- src/polygon_perimeter_area.sv -----
// Top level: APB register, front end, op queue and arithmetic back end.
//  channel | signals                          | word
//  in      | in_valid / in_stall / in_word     | vertex_t
//  out     | out_valid / out_stall / out_word  | result_t
//  cfg     | APB psel..pready                  | closed_path at 0x0
// An edge runs through the back-end steps load, ROOT_BITS square root steps
// (one bit each) and accumulate; a path's opening vertex skips the root steps.
// A closed path's last vertex adds one closing edge; the result word is held
// while out_stall is high.
// in_stall rises while the 4-word queue is full or the closing edge is issued.
// rst is synchronous; it clears the path state and sets closed_path to 1.
module polygon_perimeter_area (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [1:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_stall,
  input  ppa_pkg::vertex_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output ppa_pkg::result_t out_word
);
  import ppa_pkg::*;

  logic closed_path;
  logic f_valid, f_stall, b_valid, b_stall;
  op_t  f_word, b_word;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == ADDR_CLOSED_PATH) ? {31'b0, closed_path} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      closed_path <= 1'b1;
    end else if (psel && penable && pwrite && paddr[1] == ADDR_CLOSED_PATH) begin
      closed_path <= pwdata[0];
    end
  end

  ppa_front u_front (
    .clk, .rst, .closed_path,
    .in_valid, .in_stall, .in_word,
    .op_valid(f_valid), .op_stall(f_stall), .op_word(f_word)
  );

  ppa_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_word(f_word),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_word(b_word)
  );

  ppa_back u_back (
    .clk, .rst,
    .op_valid(b_valid), .op_stall(b_stall), .op_word(b_word),
    .out_valid, .out_stall, .out_word
  );

  a_area_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.saturated |-> out_word.area_halves <= AREA_MAX)
    else $error("area out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.vertex_count != '0)
    else $error("result with zero vertices");

endmodule

// ----- test/polygon_perimeter_area_tb.sv -----
// Testbench for polygon_perimeter_area: closed and open paths against a local predictor.
module polygon_perimeter_area_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ppa_pkg::*;

  localparam int LIMIT = 4000000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  vertex_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  result_t out_word;

  polygon_perimeter_area dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic signed [63:0] fx, fy, px, py;
  logic open_seen;
  logic [63:0] len_acc;
  logic signed [63:0] cross_acc;
  int unsigned vcount;
  logic sat_seen;
  logic closed_mode;
  result_t pending_results[$];
  int errors = 0;
  int paths = 0;
  int vertices = 0;
  int cycles = 0;
  logic stall_enable = 1;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic add_edge(logic signed [63:0] ax, ay, bx, by);
    logic [63:0] dx, dy, s, ln, mag;
    logic signed [63:0] p1, p2, sum;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    s = dx * dx + dy * dy;  // fits: at most 2^33
    s = s << (2 * FRAC_BITS);
    ln = root64(s);
    if (ln > 64'(LEN_MAX) - len_acc) begin
      len_acc = 64'(LEN_MAX);
      sat_seen = 1;
    end else begin
      len_acc = len_acc + ln;
    end
    p1 = ax * by;
    p2 = bx * ay;
    mag = (p1 >= p2) ? p1 - p2 : p2 - p1;
    sum = (p1 < p2) ? cross_acc - $signed(mag) : cross_acc + $signed(mag);
    if (sum > 64'sd2199023255551) begin
      sum = 64'sd2199023255551;
      sat_seen = 1;
    end
    if (sum < -64'sd2199023255552) begin
      sum = -64'sd2199023255552;
      sat_seen = 1;
    end
    cross_acc = sum;
  endtask

  task automatic predict_vertex(vertex_t v);
    logic signed [63:0] x, y;
    logic [63:0] a;
    result_t r;
    x = v.x_coord;
    y = v.y_coord;
    if (!open_seen) begin
      fx = x; fy = y;
      len_acc = 0; cross_acc = 0; vcount = 1; sat_seen = 0;
      open_seen = 1;
    end else begin
      add_edge(px, py, x, y);
      if (vcount < COUNT_CAP) vcount++;
      else sat_seen = 1;
    end
    px = x; py = y;
    if (v.last_vertex) begin
      a = 0;
      if (closed_mode) begin
        add_edge(x, y, fx, fy);
        a = (cross_acc < 0) ? -cross_acc : cross_acc;
        if (a > 64'(AREA_MAX)) begin
          a = 64'(AREA_MAX);
          sat_seen = 1;
        end
      end
      r.perimeter_q8 = len_acc[LEN_BITS-1:0];
      r.area_halves = a[AREA_BITS-1:0];
      r.vertex_count = vcount[COUNT_BITS-1:0];
      r.saturated = sat_seen;
      pending_results.push_back(r);
      open_seen = 0;
      paths++;
    end
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic send_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
    int g;
    vertex_t v;
    g = stall_enable ? gap_len() : 0;
    if ($urandom_range(0, 2) == 0) g = 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    v.x_coord = x;
    v.y_coord = y;
    v.last_vertex = last;
    in_valid <= 1;
    in_word <= v;
    do @(posedge clk); while (in_stall);
    predict_vertex(v);
    vertices++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {ADDR_CLOSED_PATH, 1'b0};
    pwdata <= {31'b0, m};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    closed_mode = m;
  endtask

  task automatic test_directed(logic m);
    write_mode(m);
    send_vertex(16'sd5, -16'sd7, 1'b1);                 // single vertex
    send_vertex(16'sd0, 16'sd0, 1'b0); send_vertex(16'sd3, 16'sd0, 1'b0);
    send_vertex(16'sd3, 16'sd4, 1'b1);
    send_vertex(-16'sd32768, -16'sd32768, 1'b0);        // extreme square
    send_vertex(16'sd32767, -16'sd32768, 1'b0);
    send_vertex(16'sd32767, 16'sd32767, 1'b0);
    send_vertex(-16'sd32768, 16'sd32767, 1'b1);
    send_vertex(16'sd10, 16'sd10, 1'b0); send_vertex(16'sd10, 16'sd10, 1'b1);  // zero edge
    send_vertex(-16'sd1, 16'sd0, 1'b0); send_vertex(16'sd1, -16'sd1, 1'b1);
    drain();
  endtask

  // long zigzag of extreme points: drives the vertex count past its cap
  task automatic test_saturation();
    int k;
    write_mode(1'b1);
    for (k = 0; k < 1030; k++)
      send_vertex((k % 2) ? 16'sd32767 : -16'sd32768,
                  (k % 4 < 2) ? 16'sd32767 : -16'sd32768, k == 1029);
    drain();
  endtask

  task automatic test_random(int n);
    int sent, len, k;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 40) == 0) begin
        drain();
        write_mode(1'($urandom_range(0, 1)));
      end
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_vertex(16'($urandom), 16'($urandom), k == len - 1);
        else
          send_vertex(16'(int'($urandom_range(0, 200)) - 100),
                      16'(int'($urandom_range(0, 200)) - 100), k == len - 1);
        sent++;
      end
      if (sent > n / 2 && sent < n / 2 + 10) drain();  // sender waits for all results
    end
    drain();
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    result_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_word.perimeter_q8 !== e.perimeter_q8) begin
          $error("perimeter_q8 exp %0d got %0d", e.perimeter_q8, out_word.perimeter_q8);
          errors++;
        end
        if (out_word.area_halves !== e.area_halves) begin
          $error("area_halves exp %0d got %0d", e.area_halves, out_word.area_halves);
          errors++;
        end
        if (out_word.vertex_count !== e.vertex_count) begin
          $error("vertex_count exp %0d got %0d", e.vertex_count, out_word.vertex_count);
          errors++;
        end
        if (out_word.saturated !== e.saturated) begin
          $error("saturated exp %0d got %0d", e.saturated, out_word.saturated);
          errors++;
        end
      end
    end
    out_stall <= stall_enable && ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    open_seen = 0;
    closed_mode = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed(1'b1);
    test_directed(1'b0);
    test_saturation();
    stall_enable = 0;
    test_random(100);
    stall_enable = 1;
    test_random(300);
    write_mode(1'b1);
    drain();
    if (pending_results.size() != 0) errors++;
    $display("covered %0d vertices in %0d paths, both modes, saturation", vertices, paths);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ----- files.f -----
src/ppa_pkg.sv
src/ppa_front.sv
src/ppa_queue.sv
src/ppa_back.sv
src/polygon_perimeter_area.sv
test/polygon_perimeter_area_tb.sv
